// ----- rtl/cfe_pkg.sv -----
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types and constants of the continued fraction evaluator: the
// command and status bundles between controller and datapath, and the
// fixed widths of the result fields.
// ----------------------------------------------------------------------------
package cfe_pkg;

  // Result field widths
  localparam int OUT_W  = 48;  // numerator, denominator and value fields
  localparam int FRAC_W = 32;  // fraction bits of the Q16.32 value
  localparam int WIDE_W = 64;  // width of the zero-extended numerator and denominator
  localparam int USER_W = 2;   // div_by_zero, overflow

  // Controller to datapath
  typedef struct packed {
    logic accept;      // take the input item, run the low half of p
    logic mac_hi;      // high half of a multiply-add, write the result
    logic sel_den;     // work on the denominator pair
    logic div_start;   // load the divider with the final p and q
    logic div_step;    // one restoring division step
    logic out_load;    // move the result into the output register
    logic seed;        // return the convergents to their seed values
  } cfe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;        // the term in hand closes the fraction
    logic q_zero;      // final denominator is zero
    logic out_free;    // output register can take a result this cycle
  } cfe_status_t;

endpackage

// ----- rtl/cfe_controller.sv -----
// ----------------------------------------------------------------------------
// cfe_controller
// Sequencer of the evaluator: four multiply-add half steps per term, then
// for the final term one divider load, one step a cycle unless the denominator
// is zero, and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module cfe_controller import cfe_pkg::*; #(
  parameter int CONV_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  cfe_status_t status,
  output cfe_cmd_t    cmd
);

  localparam int DIV_STEPS = CONV_WIDTH + FRAC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    IDLE,
    P_HI,
    Q_LO,
    Q_HI,
    DIV_LOAD,
    DIV_RUN,
    EMIT
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;

  // Decode commands from the current state
  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = P_HI;
        end
      end
      P_HI: begin
        cmd.mac_hi = 1'b1;
        state_next = Q_LO;
      end
      Q_LO: begin
        cmd.sel_den = 1'b1;
        state_next  = Q_HI;
      end
      Q_HI: begin
        cmd.sel_den = 1'b1;
        cmd.mac_hi  = 1'b1;
        state_next  = status.last ? DIV_LOAD : IDLE;
      end
      DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = status.q_zero ? EMIT : DIV_RUN;
      end
      DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.seed     = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state and the division step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == DIV_RUN) begin
        count <= count + CNT_W'(1);
      end else begin
        count <= '0;
      end
    end
  end

endmodule

// ----- rtl/cfe_datapath.sv -----
// ----------------------------------------------------------------------------
// cfe_datapath
// Convergent registers, one shared saturating multiply-add that works on a
// half of the convergent per cycle, a bit-serial restoring divider for the
// Q16.32 value, and the output register.
// ----------------------------------------------------------------------------
module cfe_datapath import cfe_pkg::*; #(
  parameter int TERM_WIDTH = 8,
  parameter int CONV_WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfe_cmd_t                 cmd,
  output cfe_status_t              status,
  input  logic [TERM_WIDTH-1:0]    s_term,
  input  logic                     s_last,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [3*OUT_W-1:0]       m_tdata,
  output logic [USER_W-1:0]        m_tuser
);

  localparam int HALF_W = (CONV_WIDTH + 1) / 2;
  localparam int PROD_W = TERM_WIDTH + HALF_W;
  localparam int ACC_W  = CONV_WIDTH + TERM_WIDTH + 1;
  localparam int DVD_W  = CONV_WIDTH + FRAC_W;
  localparam logic [CONV_WIDTH-1:0] CONV_MAX = '1;

  // Convergent state
  logic [CONV_WIDTH-1:0] num_cur;
  logic [CONV_WIDTH-1:0] num_prev;
  logic [CONV_WIDTH-1:0] den_cur;
  logic [CONV_WIDTH-1:0] den_prev;
  logic                  ovf_seen;

  // Working registers
  logic [TERM_WIDTH-1:0] term_q;
  logic                  last_q;
  logic [ACC_W-1:0]      acc;
  logic [CONV_WIDTH-1:0] p_tmp;
  logic [DVD_W-1:0]      dvd;
  logic [CONV_WIDTH-1:0] rem;
  logic [OUT_W-1:0]      quo;
  logic                  sticky;

  // Multiply-add signals
  logic [TERM_WIDTH-1:0] a_op;
  logic [CONV_WIDTH-1:0] x_op;
  logic [CONV_WIDTH-1:0] y_op;
  logic [HALF_W-1:0]     x_half;
  logic [PROD_W-1:0]     prod;
  logic [ACC_W-1:0]      sum_hi;
  logic                  mac_ovf;
  logic [CONV_WIDTH-1:0] mac_res;

  // Divider signals
  logic [CONV_WIDTH:0]   rem_sh;
  logic [CONV_WIDTH:0]   rem_sub;
  logic                  q_bit;

  // Output formatting
  logic [WIDE_W-1:0]     num_wide;
  logic [WIDE_W-1:0]     den_wide;
  logic                  den_zero;
  logic [OUT_W-1:0]      value;

  // Select operands: term from the port on the accept cycle
  assign a_op   = cmd.accept ? s_term : term_q;
  assign x_op   = cmd.sel_den ? den_cur : num_cur;
  assign y_op   = cmd.sel_den ? den_prev : num_prev;
  assign x_half = cmd.mac_hi ? HALF_W'(x_op >> HALF_W) : x_op[HALF_W-1:0];

  // Multiply one half, then add the high half onto the partial sum
  assign prod    = PROD_W'(a_op) * PROD_W'(x_half);
  assign sum_hi  = acc + (ACC_W'(prod) << HALF_W);
  assign mac_ovf = |sum_hi[ACC_W-1:CONV_WIDTH];
  assign mac_res = mac_ovf ? CONV_MAX : sum_hi[CONV_WIDTH-1:0];

  // Restoring division step
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign q_bit   = rem_sh >= {1'b0, den_cur};
  assign rem_sub = rem_sh - {1'b0, den_cur};

  // Format the result fields
  assign num_wide = WIDE_W'(num_cur);
  assign den_wide = WIDE_W'(den_cur);
  assign den_zero = (den_cur == '0);
  assign value    = (den_zero || sticky) ? '1 : quo;

  assign status.last     = last_q;
  assign status.q_zero   = den_zero;
  assign status.out_free = !m_tvalid || m_tready;

  // Convergents, overflow mark and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cur  <= CONV_WIDTH'(1);
      num_prev <= '0;
      den_cur  <= '0;
      den_prev <= CONV_WIDTH'(1);
      ovf_seen <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.mac_hi) begin
        ovf_seen <= ovf_seen | mac_ovf;
        if (cmd.sel_den) begin
          num_prev <= num_cur;
          num_cur  <= p_tmp;
          den_prev <= den_cur;
          den_cur  <= mac_res;
        end
      end
      if (cmd.seed) begin
        num_cur  <= CONV_WIDTH'(1);
        num_prev <= '0;
        den_cur  <= '0;
        den_prev <= CONV_WIDTH'(1);
        ovf_seen <= 1'b0;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      term_q <= s_term;
      last_q <= s_last;
    end
    if (cmd.accept || (cmd.sel_den && !cmd.mac_hi)) begin
      acc <= ACC_W'(prod) + ACC_W'(y_op);
    end
    if (cmd.mac_hi && !cmd.sel_den) begin
      p_tmp <= mac_res;
    end
    if (cmd.div_start) begin
      dvd    <= {num_cur, FRAC_W'(0)};
      rem    <= '0;
      quo    <= '0;
      sticky <= 1'b0;
    end else if (cmd.div_step) begin
      dvd    <= dvd << 1;
      rem    <= q_bit ? rem_sub[CONV_WIDTH-1:0] : rem_sh[CONV_WIDTH-1:0];
      quo    <= {quo[OUT_W-2:0], q_bit};
      sticky <= sticky | quo[OUT_W-1];
    end
    if (cmd.out_load) begin
      m_tdata <= {value, den_wide[OUT_W-1:0], num_wide[OUT_W-1:0]};
      m_tuser <= {ovf_seen, den_zero};
    end
  end

endmodule

// ----- rtl/continued_fraction_evaluator.sv -----
// ----------------------------------------------------------------------------
// continued_fraction_evaluator
// Evaluates a simple continued fraction from its partial quotients and
// returns the final convergent p/q and its value as unsigned Q16.32.
//
//  channel | ports                       | payload
//  --------+-----------------------------+---------------------------------
//  in      | s_tvalid s_tready s_tdata   | term in s_tdata, is_last on
//          | s_tlast                     | s_tlast
//  out     | m_tvalid m_tready m_tdata   | numerator, denominator, value in
//          | m_tuser                     | m_tdata; flags in m_tuser
//
// For each term the shared multiplier works on half a convergent per cycle,
// two halves for p and two for q.
// The final term then loads and runs the bit-serial divider; a zero denominator
// skips the divider.
// The output register holds a result while the next fraction's terms are
// taken; a final term waits only if that register is still full.
// Reset is synchronous and returns the convergents to their seed values.
// ----------------------------------------------------------------------------
module continued_fraction_evaluator import cfe_pkg::*; #(
  parameter int TERM_WIDTH = 8,
  parameter int CONV_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((TERM_WIDTH+7)/8)*8-1:0]   s_tdata,   // term
  input  logic                              s_tlast,   // is_last
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [3*OUT_W-1:0]                m_tdata,   // numerator, denominator, value
  output logic [USER_W-1:0]                 m_tuser    // div_by_zero, overflow
);

  cfe_cmd_t    cmd;
  cfe_status_t status;

  // Sequence the terms and the division
  cfe_controller #(
    .CONV_WIDTH (CONV_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Convergents, divider and output register
  cfe_datapath #(
    .TERM_WIDTH (TERM_WIDTH),
    .CONV_WIDTH (CONV_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_term   (s_tdata[TERM_WIDTH-1:0]),
    .s_last   (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- rtl/cfe_checker.sv -----
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks of the evaluator over time, bound to the top level.
// ----------------------------------------------------------------------------
module cfe_checker import cfe_pkg::*; (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [3*OUT_W-1:0]                m_tdata,
  input logic [USER_W-1:0]                 m_tuser
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An accepted term keeps the input closed while its multiply-adds run
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("input reopened before the term was done");

  // A zero denominator gives an all-ones value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[3*OUT_W-1:2*OUT_W] == '1)
    else $error("zero denominator without saturated value");

  // The zero-denominator flag matches the denominator field
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[2*OUT_W-1:OUT_W] == '0)
    else $error("zero-denominator flag with nonzero denominator");

  // No result straight after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind continued_fraction_evaluator cfe_checker u_cfe_checker (.*);
